/* rtl/tcf_pkg.sv */
// Shared types, constants and the arctangent table of the tilt filter.
// No dependencies.
package tcf_pkg;

  localparam int STEP_W    = 5;
  localparam int ACC_W     = 29;
  localparam int CW        = 34;
  localparam int ZW        = 25;
  localparam logic [16:0] GAIN_K_Q16 = 17'd107923;
  localparam logic signed [15:0] ANGLE_MAX = 16'sd23040;

  localparam logic [2:0] CFG_OFFSET_X  = 3'd0;
  localparam logic [2:0] CFG_OFFSET_Y  = 3'd1;
  localparam logic [2:0] CFG_OFFSET_Z  = 3'd2;
  localparam logic [2:0] CFG_BIAS_X    = 3'd3;
  localparam logic [2:0] CFG_BIAS_Y    = 3'd4;
  localparam logic [2:0] CFG_GAIN      = 3'd5;
  localparam logic [2:0] CFG_WEIGHT    = 3'd6;

  typedef struct packed {
    logic [14:0]        offset_x;
    logic [14:0]        offset_y;
    logic [14:0]        offset_z;
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_y;
    logic [15:0]        gain;
    logic [15:0]        weight;
  } cfg_t;

  typedef enum logic [2:0] {
    BOP_NONE,
    BOP_GYRO,
    BOP_DIFF,
    BOP_MLO,
    BOP_MHI,
    BOP_FIN
  } blend_op_t;

  typedef struct packed {
    logic              load;
    logic              pass_init;
    logic              pass_end;
    logic              cordic_step;
    logic [1:0]        pass;
    logic [STEP_W-1:0] step;
    blend_op_t         bop;
    logic              axis;
  } cmd_t;

  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tcf_in_if.sv */
// Input sample channel: valid/ready plus one raw IMU word.
// No dependencies.
interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, output ready);
endinterface

/* rtl/tcf_out_if.sv */
// Result channel: valid/ready plus pitch and roll.
// No dependencies.
interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  modport source (output valid, pitch, roll, input ready);
  modport sink (input valid, pitch, roll, output ready);
endinterface

/* rtl/tcf_cfg_if.sv */
// Configuration write channel: valid/ready plus register index and data.
// No dependencies.
interface tcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tcf_datapath.sv */
// Datapath: accel correction, shared CORDIC vectoring unit, blend multiplier.
// Depends on tcf_pkg; driven by tcf_ctrl commands.
module tcf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tcf_pkg::cfg_t       cfg,
  input  tcf_pkg::cmd_t       cmd,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  rate_x,
  input  logic signed [15:0]  rate_y,
  output logic signed [15:0]  pitch,
  output logic signed [15:0]  roll
);

  function automatic logic signed [tcf_pkg::ACC_W-1:0] corr(input logic signed [15:0] raw,
                                                           input logic [14:0] off);
    logic signed [16:0] v;
    if (raw[15]) begin
      v = $signed({raw[15], raw}) + $signed({2'b00, off});
    end else begin
      v = $signed({raw[15], raw}) - $signed({2'b00, off});
    end
    return $signed({v, 12'd0});
  endfunction

  logic signed [tcf_pkg::ACC_W-1:0] ax_r, ay_r, az_r;
  logic signed [15:0]               rx_r, ry_r;
  logic signed [tcf_pkg::CW-1:0]    x_r, y_r, m_r;
  logic signed [tcf_pkg::ZW-1:0]    z_r, pacc_r, racc_r;
  logic                             zero_r;
  logic signed [33:0]               prod_r;
  logic signed [35:0]               diff_r;
  logic signed [55:0]               base_r;
  logic [33:0]                      plo_r;
  logic signed [34:0]               phi_r;
  logic signed [15:0]               pest_r, rest_r;

  logic signed [tcf_pkg::ACC_W-1:0] ksrc, az_abs;
  logic signed [46:0]               kprod;
  logic signed [tcf_pkg::CW-1:0]    xin, yin, xs, ys;
  logic signed [tcf_pkg::ZW-1:0]    ang;
  logic signed [15:0]               est, rate, bias;
  logic signed [tcf_pkg::ZW-1:0]    acc;
  logic signed [16:0]               rdiff;
  logic signed [55:0]               sum;
  logic signed [23:0]               rr;
  logic signed [15:0]               sat;

  always_comb begin
    ksrc   = cmd.pass[1] ? ay_r : ax_r;
    kprod  = ksrc * $signed({1'b0, tcf_pkg::GAIN_K_Q16});
    az_abs = az_r[tcf_pkg::ACC_W-1] ? -az_r : az_r;
    case (cmd.pass)
      2'd0: begin
        xin = {{(tcf_pkg::CW-tcf_pkg::ACC_W){az_abs[tcf_pkg::ACC_W-1]}}, az_abs};
        yin = {{(tcf_pkg::CW-tcf_pkg::ACC_W){ay_r[tcf_pkg::ACC_W-1]}}, ay_r};
      end
      2'd2: begin
        xin = {{(tcf_pkg::CW-tcf_pkg::ACC_W){az_abs[tcf_pkg::ACC_W-1]}}, az_abs};
        yin = {{(tcf_pkg::CW-tcf_pkg::ACC_W){ax_r[tcf_pkg::ACC_W-1]}}, ax_r};
      end
      default: begin
        xin = m_r;
        yin = {{3{kprod[46]}}, kprod[46:16]};
      end
    endcase
    xs  = x_r >>> cmd.step;
    ys  = y_r >>> cmd.step;
    ang = $signed({3'b000, tcf_pkg::atan_q16(cmd.step)});

    est   = cmd.axis ? rest_r : pest_r;
    rate  = cmd.axis ? ry_r : rx_r;
    bias  = cmd.axis ? cfg.bias_y : cfg.bias_x;
    acc   = cmd.axis ? racc_r : pacc_r;
    rdiff = $signed({rate[15], rate}) - $signed({bias[15], bias});
    sum   = base_r + $signed({{3{phi_r[34]}}, phi_r, 18'd0}) + $signed({22'd0, plo_r});
    rr    = sum[55:32];
    if (rr > $signed({{8{1'b0}}, tcf_pkg::ANGLE_MAX})) begin
      sat = tcf_pkg::ANGLE_MAX;
    end else if (rr < -$signed({{8{1'b0}}, tcf_pkg::ANGLE_MAX})) begin
      sat = -tcf_pkg::ANGLE_MAX;
    end else begin
      sat = rr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= corr(accel_x, cfg.offset_x);
      ay_r <= corr(accel_y, cfg.offset_y);
      az_r <= corr(accel_z, cfg.offset_z);
      rx_r <= rate_x;
      ry_r <= rate_y;
    end
    if (cmd.pass_init) begin
      x_r    <= xin;
      y_r    <= yin;
      z_r    <= '0;
      zero_r <= (xin == '0) && (yin == '0);
    end else if (cmd.cordic_step) begin
      if (y_r < 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + ang;
      end
    end
    if (cmd.pass_end) begin
      case (cmd.pass)
        2'd1:    pacc_r <= zero_r ? '0 : z_r;
        2'd3:    racc_r <= zero_r ? '0 : z_r;
        default: m_r <= zero_r ? '0 : x_r;
      endcase
    end
    case (cmd.bop)
      tcf_pkg::BOP_GYRO: prod_r <= rdiff * $signed({1'b0, cfg.gain});
      tcf_pkg::BOP_DIFF: begin
        diff_r <= $signed({{4{est[15]}}, est, 16'd0}) + $signed({{2{prod_r[33]}}, prod_r})
                - $signed({{4{acc[tcf_pkg::ZW-1]}}, acc, 7'd0});
        base_r <= $signed({{8{acc[tcf_pkg::ZW-1]}}, acc, 23'd0})
                + $signed({24'd0, 1'b1, 31'd0});
      end
      tcf_pkg::BOP_MLO: plo_r <= cfg.weight * diff_r[17:0];
      tcf_pkg::BOP_MHI: phi_r <= $signed({1'b0, cfg.weight}) * $signed(diff_r[35:18]);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pest_r <= '0;
      rest_r <= '0;
    end else if (cmd.bop == tcf_pkg::BOP_FIN) begin
      if (cmd.axis) begin
        rest_r <= sat;
      end else begin
        pest_r <= sat;
      end
    end
  end

  assign pitch = pest_r;
  assign roll  = rest_r;

endmodule

/* rtl/tcf_ctrl.sv */
// Sequencer: four CORDIC passes, then the two-axis blend, then the result handshake.
// Depends on tcf_pkg; drives tcf_datapath.
module tcf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tcf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_STEP, S_END, S_WAIT, S_GYRO, S_DIFF, S_MLO, S_MHI, S_FIN
  } state_t;

  localparam logic [tcf_pkg::STEP_W-1:0] LAST_STEP = tcf_pkg::STEP_W'(CORDIC_STEPS - 1);

  state_t                     state_r;
  logic [1:0]                 pass_r;
  logic [tcf_pkg::STEP_W-1:0] step_r;
  logic                       axis_r;
  logic                       in_ready_r, out_valid_r;

  always_comb begin
    cmd             = '0;
    cmd.load        = in_valid && in_ready_r;
    cmd.pass_init   = (state_r == S_INIT);
    cmd.cordic_step = (state_r == S_STEP);
    cmd.pass_end    = (state_r == S_END);
    cmd.pass        = pass_r;
    cmd.step        = step_r;
    cmd.axis        = axis_r;
    case (state_r)
      S_GYRO:  cmd.bop = tcf_pkg::BOP_GYRO;
      S_DIFF:  cmd.bop = tcf_pkg::BOP_DIFF;
      S_MLO:   cmd.bop = tcf_pkg::BOP_MLO;
      S_MHI:   cmd.bop = tcf_pkg::BOP_MHI;
      S_FIN:   cmd.bop = tcf_pkg::BOP_FIN;
      default: cmd.bop = tcf_pkg::BOP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= '0;
      step_r      <= '0;
      axis_r      <= 1'b0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && axis_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            pass_r     <= '0;
            state_r    <= S_INIT;
          end
        end
        S_INIT: begin
          step_r  <= '0;
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (step_r == LAST_STEP) begin
            state_r <= S_END;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_END: begin
          if (pass_r == 2'd3) begin
            axis_r  <= 1'b0;
            state_r <= S_WAIT;
          end else begin
            pass_r  <= pass_r + 1'b1;
            state_r <= S_INIT;
          end
        end
        S_WAIT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_GYRO;
          end
        end
        S_GYRO: state_r <= S_DIFF;
        S_DIFF: state_r <= S_MLO;
        S_MLO:  state_r <= S_MHI;
        S_MHI:  state_r <= S_FIN;
        S_FIN: begin
          if (!axis_r) begin
            axis_r  <= 1'b1;
            state_r <= S_GYRO;
          end else begin
            in_ready_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE) else $error("ready outside idle");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> step_r <= LAST_STEP) else $error("step overrun");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && axis_r) |=> out_valid_r) else $error("result not raised");
  a_blend_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GYRO || state_r == S_DIFF || state_r == S_MLO || state_r == S_MHI
     || state_r == S_FIN) |-> !out_valid_r) else $error("estimate changed under pending word");
`endif

endmodule

/* rtl/tilt_complementary_filter_core.sv */
// Top level of the tilt complementary filter: configuration registers and wiring.
// Depends on tcf_pkg, the channel interfaces, tcf_ctrl and tcf_datapath.
//
// One sample word in gives one pitch/roll word out. Each sample passes
// through the single shared CORDIC unit, which runs four vectoring passes
// one micro-rotation per cycle, followed by a two-axis blend. A finished
// word waits in the output register; the next sample is taken as soon as
// the result is posted and is held before its blend until the previous
// word is taken. Configuration writes are always ready.
module tilt_complementary_filter_core #(
  parameter int CORDIC_STEPS = 16
) (
  input logic    clk,
  input logic    rst_n,
  tcf_in_if.sink   in_ch,
  tcf_out_if.source out_ch,
  tcf_cfg_if.sink  cfg_ch
);

  tcf_pkg::cfg_t cfg_r;
  tcf_pkg::cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x <= '0;
      cfg_r.offset_y <= '0;
      cfg_r.offset_z <= '0;
      cfg_r.bias_x   <= '0;
      cfg_r.bias_y   <= '0;
      cfg_r.gain     <= 16'd1281;
      cfg_r.weight   <= 16'd62259;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tcf_pkg::CFG_OFFSET_X: cfg_r.offset_x <= cfg_ch.data[14:0];
        tcf_pkg::CFG_OFFSET_Y: cfg_r.offset_y <= cfg_ch.data[14:0];
        tcf_pkg::CFG_OFFSET_Z: cfg_r.offset_z <= cfg_ch.data[14:0];
        tcf_pkg::CFG_BIAS_X:   cfg_r.bias_x   <= $signed(cfg_ch.data);
        tcf_pkg::CFG_BIAS_Y:   cfg_r.bias_y   <= $signed(cfg_ch.data);
        tcf_pkg::CFG_GAIN:     cfg_r.gain     <= cfg_ch.data;
        tcf_pkg::CFG_WEIGHT:   cfg_r.weight   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  tcf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tcf_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .accel_x (in_ch.accel_x),
    .accel_y (in_ch.accel_y),
    .accel_z (in_ch.accel_z),
    .rate_x  (in_ch.rate_x),
    .rate_y  (in_ch.rate_y),
    .pitch   (out_ch.pitch),
    .roll    (out_ch.roll)
  );

endmodule

/* dv/tcf_checker.sv */
// Scoreboard for the tilt filter: watches the sample, result and register channels,
// predicts pitch/roll per sample and compares each result word field by field.
// Depends on tcf_pkg and the channel interfaces tcf_in_if, tcf_out_if and tcf_cfg_if.
module tcf_checker (
  input  logic clk,
  input  logic rst_n,
  tcf_in_if    in_ch,
  tcf_out_if   out_ch,
  tcf_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam longint ATAN_DEG_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };
  localparam longint K_Q16 = 107923;
  localparam longint ANGLE_LIM = 23040;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } tilt_word_t;

  logic [14:0]        offset_x, offset_y, offset_z;
  logic signed [15:0] bias_x, bias_y;
  logic [15:0]        gain, weight;
  logic signed [15:0] pitch_est, roll_est;
  tilt_word_t         tilt_words_due[$];

  function automatic longint remove_offset(logic signed [15:0] raw, logic [14:0] off);
    longint v;
    v = (raw >= 0) ? longint'(raw) - longint'(off) : longint'(raw) + longint'(off);
    return v * 4096;
  endfunction

  function automatic longint rotate_to_axis(longint x, longint y, output longint mag);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_DEG_Q16[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_DEG_Q16[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint tilt_deg_q16(longint num, longint a, longint b);
    longint m, unused;
    void'(rotate_to_axis((b < 0) ? -b : b, a, m));
    return rotate_to_axis(m, (num * K_Q16) >>> 16, unused);
  endfunction

  function automatic logic signed [15:0] fuse_angle(logic signed [15:0] est,
      logic signed [15:0] rate, logic signed [15:0] bias, longint acc_deg);
    longint gyro_q, acc_q, w, r;
    gyro_q = longint'(est) * 65536 + (longint'(rate) - longint'(bias)) * longint'(gain);
    acc_q  = acc_deg * 128;
    w      = longint'(weight);
    r      = (w * gyro_q + (65536 - w) * acc_q + (64'sd1 <<< 31)) >>> 32;
    if (r > ANGLE_LIM) r = ANGLE_LIM;
    if (r < -ANGLE_LIM) r = -ANGLE_LIM;
    return r[15:0];
  endfunction

  always @(posedge clk) begin
    tilt_word_t got, want;
    longint ax, ay, az;
    if (!rst_n) begin
      offset_x <= '0; offset_y <= '0; offset_z <= '0;
      bias_x <= '0; bias_y <= '0;
      gain <= 16'd1281; weight <= 16'd62259;
      pitch_est = '0; roll_est = '0;
      tilt_words_due.delete();
      fail_count = 0;
      words_checked = 0;
      pending = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.pitch = out_ch.pitch;
        got.roll  = out_ch.roll;
        if (tilt_words_due.size() == 0) begin
          $error("result word with nothing expected: pitch %0d roll %0d", got.pitch, got.roll);
          fail_count++;
        end else begin
          want = tilt_words_due.pop_front();
          if (got.pitch !== want.pitch) begin
            $error("pitch mismatch: expected %0d, got %0d", want.pitch, got.pitch);
            fail_count++;
          end
          if (got.roll !== want.roll) begin
            $error("roll mismatch: expected %0d, got %0d", want.roll, got.roll);
            fail_count++;
          end
        end
        words_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        ax = remove_offset(in_ch.accel_x, offset_x);
        ay = remove_offset(in_ch.accel_y, offset_y);
        az = remove_offset(in_ch.accel_z, offset_z);
        pitch_est = fuse_angle(pitch_est, in_ch.rate_x, bias_x, tilt_deg_q16(ax, ay, az));
        roll_est  = fuse_angle(roll_est, in_ch.rate_y, bias_y, tilt_deg_q16(ay, ax, az));
        want.pitch = pitch_est;
        want.roll  = roll_est;
        tilt_words_due.push_back(want);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          tcf_pkg::CFG_OFFSET_X: offset_x <= cfg_ch.data[14:0];
          tcf_pkg::CFG_OFFSET_Y: offset_y <= cfg_ch.data[14:0];
          tcf_pkg::CFG_OFFSET_Z: offset_z <= cfg_ch.data[14:0];
          tcf_pkg::CFG_BIAS_X:   bias_x <= cfg_ch.data;
          tcf_pkg::CFG_BIAS_Y:   bias_y <= cfg_ch.data;
          tcf_pkg::CFG_GAIN:     gain <= cfg_ch.data;
          tcf_pkg::CFG_WEIGHT:   weight <= cfg_ch.data;
          default: ;
        endcase
      end
      pending = tilt_words_due.size();
    end
  end
endmodule

/* dv/tb_top.sv */
// Top of the tilt filter bench: clock, reset, sample and register stimulus,
// result back-pressure and the verdict. Depends on tcf_pkg, the channel
// interfaces, tilt_complementary_filter_core and tcf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE = 100;
  localparam int PER_PHASE = 215;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, words_checked;
  int   cycles = 0;
  int   samples_sent = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;

  tcf_in_if  in_ch();
  tcf_out_if out_ch();
  tcf_cfg_if cfg_ch();

  tilt_complementary_filter_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tcf_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
      logic signed [15:0] az, logic signed [15:0] rx, logic signed [15:0] ry, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= ax;
    in_ch.accel_y <= ay;
    in_ch.accel_z <= az;
    in_ch.rate_x  <= rx;
    in_ch.rate_y  <= ry;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_setting(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
      logic [15:0] bx, logic [15:0] by, logic [15:0] g, logic [15:0] w);
    write_reg(tcf_pkg::CFG_OFFSET_X, ox);
    write_reg(tcf_pkg::CFG_OFFSET_Y, oy);
    write_reg(tcf_pkg::CFG_OFFSET_Z, oz);
    write_reg(tcf_pkg::CFG_BIAS_X, bx);
    write_reg(tcf_pkg::CFG_BIAS_Y, by);
    write_reg(tcf_pkg::CFG_GAIN, g);
    write_reg(tcf_pkg::CFG_WEIGHT, w);
  endtask

  function automatic logic signed [15:0] pick_field(bit plausible, int span);
    if (plausible) return 16'($signed($urandom_range(0, 2 * span)) - span);
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: return 16'sd32767;
      2: return -16'sd32768;
      3: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(int n);
    bit p;
    for (int i = 0; i < n; i++) begin
      p = ($urandom_range(0, 9) < 6);
      send_sample(pick_field(p, 20000), pick_field(p, 20000), pick_field(p, 20000),
                  pick_field(p, 3000), pick_field(p, 3000), calm ? 0 : $urandom_range(0, 13));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.rate_x = '0; in_ch.rate_y = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(0, 0, 0, 32767, -32768, 0);
    send_sample(32767, 32767, 32767, 32767, 32767, 0);
    send_sample(-32768, -32768, -32768, -32768, -32768, 0);
    send_sample(16384, 0, 0, 0, 0, 1);
    send_sample(-16384, 0, 0, 0, 0, 0);
    send_sample(0, 16384, 0, 0, 0, 0);
    send_sample(0, -16384, 0, 0, 0, 2);
    send_sample(0, 0, 16384, 0, 0, 0);
    send_sample(0, 0, -16384, 0, 0, 0);
    send_sample(32767, -32768, 0, 1, -1, 0);
    send_sample(-32768, 32767, 1, -1, 1, 3);
    send_sample(1, -1, -1, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_sample(0, 0, 16384, 32767, 32767, 0);
    for (int i = 0; i < 6; i++) send_sample(0, 0, 16384, -32768, -32768, 0);
    run_random(PER_PHASE - 25);
    drain();

    load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    write_reg(3'd7, 16'($urandom));
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(5, -5, 0, 100, -100, 0);
    run_random(PER_PHASE);
    drain();

    load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    hold_req = 1'b1;
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(100, -100, 0, 32767, -32768, 0);
    send_sample(-32768, 32767, -1, -32768, 32767, 0);
    run_random(PER_PHASE);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      load_setting(16'($urandom_range(0, 2000)) | (16'($urandom_range(0, 1)) << 15),
                   16'($urandom_range(0, 2000)), 16'($urandom),
                   16'($urandom), 16'($signed($urandom_range(0, 400)) - 200),
                   16'($urandom), 16'($urandom));
      calm = (ph == 1);
      run_random(PER_PHASE);
      drain();
    end
    calm = 1'b0;

    load_setting(16'd50, 16'd60, 16'd70, 16'd12, -16'sd9, 16'd1281, 16'd62259);
    write_reg(3'd7, 16'hFFFF);
    run_random(PER_PHASE / 2);
    drain();

    $display("Sent %0d samples over seven register settings; checked %0d result words.",
             samples_sent, words_checked);
    $display("Covered offsets, biases, gain and weight at both extremes, long output hold.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end
endmodule

/* filelist.f */
rtl/tcf_pkg.sv
rtl/tcf_in_if.sv
rtl/tcf_out_if.sv
rtl/tcf_cfg_if.sv
rtl/tcf_datapath.sv
rtl/tcf_ctrl.sv
rtl/tilt_complementary_filter_core.sv
dv/tcf_checker.sv
dv/tb_top.sv
